// File: rtl/hs_pkg.sv
// hs_pkg: shared types and constants for the heap sort engine
// word formats of both channels, controller command and datapath status
// no dependencies
`default_nettype none

package hs_pkg;

  // default store capacity
  localparam int DEPTH_DEF = 64;

  // input word
  typedef struct packed {
    logic signed [31:0] value;
    logic               last_item;
  } in_word_t;

  // result word
  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               last_result;
    logic               truncated;
  } out_word_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_wr;     // store an input word
    logic build_init;  // start heap build: index = n/2, end = n
    logic top_rd;      // read entry index-1 as sift start
    logic v_load;      // hold the sift value from read port 0
    logic i_dec;       // index down by one
    logic child_rd;    // read both children of the hole
    logic step_down;   // move larger child up, hole goes down
    logic settle;      // write held value into the hole
    logic ext_init;    // start extraction: index = n
    logic ext_rd;      // read root and entry index-1
    logic ext_swap;    // root to the end, sift the old end value from the root
    logic out_init;    // output index to zero
    logic out_rd;      // read next output entry
    logic finish;      // clear batch state
  } hs_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic i_zero;    // index is zero
    logic i_le1;     // index is at most one
    logic c_ge_end;  // hole has no child inside the heap
    logic v_lt_big;  // held value below the larger child
    logic k_last;    // output index on the final entry
  } hs_stat_t;

endpackage

`default_nettype wire

// File: rtl/hs_datapath.sv
// hs_datapath: value store, sift registers and result register
// depends on hs_pkg; driven by hs_ctrl through hs_cmd_t
`default_nettype none

module hs_datapath
  import hs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire hs_cmd_t   cmd,
  input  wire in_word_t  in_word,
  output hs_stat_t       stat,
  output logic           out_valid,
  output out_word_t      out_word
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = CW + 1;

  // value store
  logic [31:0] mem [DEPTH];

  // batch state
  logic [CW-1:0] count_r;
  logic          ovf_r;

  // loop and sift registers
  logic [CW-1:0]      i_r;
  logic [CW-1:0]      end_r;
  logic [AW-1:0]      p_r;
  logic [AW-1:0]      c_r;
  logic               c1ok_r;
  logic signed [31:0] v_r;
  logic signed [31:0] rd0_r;
  logic signed [31:0] rd1_r;
  logic               out_vld_r;
  logic               out_last_r;

  // derived values
  logic [IW-1:0]      child_w;
  logic [IW-1:0]      child1_w;
  logic               c1_lt_end;
  logic [CW-1:0]      i_m1;
  logic               take_right;
  logic signed [31:0] big_val;
  logic [AW-1:0]      big_idx;
  logic               has_room;

  logic               we;
  logic [AW-1:0]      wa;
  logic [31:0]        wd;
  logic [AW-1:0]      ra0;
  logic [AW-1:0]      ra1;

  // child indices of the hole
  assign child_w   = (IW'(p_r) << 1) | IW'(1);
  assign child1_w  = child_w + IW'(1);
  assign c1_lt_end = child1_w < IW'(end_r);
  assign i_m1      = i_r - CW'(1);
  assign has_room  = count_r < CW'(DEPTH);

  // larger of the two children
  assign take_right = c1ok_r && (rd0_r < rd1_r);
  assign big_val    = take_right ? rd1_r : rd0_r;
  assign big_idx    = take_right ? (c_r + AW'(1)) : c_r;

  // status
  assign stat.i_zero   = (i_r == '0);
  assign stat.i_le1    = (i_r <= CW'(1));
  assign stat.c_ge_end = child_w >= IW'(end_r);
  assign stat.v_lt_big = v_r < big_val;
  assign stat.k_last   = (i_r == count_r - CW'(1));

  // write port select
  always_comb begin
    we = 1'b0;
    wa = p_r;
    wd = v_r;
    if (cmd.load_wr) begin
      we = has_room;
      wa = count_r[AW-1:0];
      wd = in_word.value;
    end else if (cmd.step_down) begin
      we = 1'b1;
      wd = big_val;
    end else if (cmd.settle) begin
      we = 1'b1;
    end else if (cmd.ext_swap) begin
      we = 1'b1;
      wa = i_m1[AW-1:0];
      wd = rd0_r;
    end
  end

  // read address select
  always_comb begin
    ra0 = i_r[AW-1:0];
    ra1 = i_m1[AW-1:0];
    if (cmd.top_rd) begin
      ra0 = i_m1[AW-1:0];
    end else if (cmd.child_rd) begin
      ra0 = child_w[AW-1:0];
      ra1 = child1_w[AW-1:0];
    end else if (cmd.ext_rd) begin
      ra0 = '0;
    end
  end

  // store: one write, two registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd0_r <= mem[ra0];
    rd1_r <= mem[ra1];
  end

  // batch count and overflow flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.finish) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.load_wr) begin
      if (has_room) begin
        count_r <= count_r + CW'(1);
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  // loop index, heap end, hole and held value
  always_ff @(posedge clk) begin
    if (cmd.build_init) begin
      i_r   <= count_r >> 1;
      end_r <= count_r;
    end else if (cmd.i_dec) begin
      i_r <= i_m1;
    end else if (cmd.ext_init) begin
      i_r <= count_r;
    end else if (cmd.out_init) begin
      i_r <= '0;
    end else if (cmd.out_rd) begin
      i_r <= i_r + CW'(1);
    end
    if (cmd.ext_swap) begin
      end_r <= i_m1;
    end
    if (cmd.top_rd) begin
      p_r <= i_m1[AW-1:0];
    end else if (cmd.step_down) begin
      p_r <= big_idx;
    end else if (cmd.ext_swap) begin
      p_r <= '0;
    end
    if (cmd.v_load) begin
      v_r <= rd0_r;
    end else if (cmd.ext_swap) begin
      v_r <= rd1_r;
    end
    if (cmd.child_rd) begin
      c_r    <= child_w[AW-1:0];
      c1ok_r <= c1_lt_end;
    end
    out_last_r <= stat.k_last;
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= cmd.out_rd;
    end
  end

  // result word straight from the read register
  assign out_valid             = out_vld_r;
  assign out_word.sorted_value = rd0_r;
  assign out_word.last_result  = out_last_r;
  assign out_word.truncated    = ovf_r;

endmodule

`default_nettype wire

// File: rtl/hs_ctrl.sv
// hs_ctrl: sequencer for load, heap build, extraction and output run
// depends on hs_pkg; drives hs_datapath through hs_cmd_t
`default_nettype none

module hs_ctrl
  import hs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic     in_last,
  input  wire hs_stat_t stat,
  output hs_cmd_t       cmd,
  output logic          busy
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_BUILD_INIT,
    S_BUILD_NEXT,
    S_BUILD_LOAD,
    S_SIFT_CHK,
    S_SIFT_CMP,
    S_EXT_CHK,
    S_EXT_SWAP,
    S_OUT,
    S_OUT_END
  } state_t;

  state_t state_r, state_nxt;
  logic   phase_r, phase_nxt;   // 1 while extracting
  logic   busy_r, busy_nxt;
  state_t sift_ret;

  // where a finished sift goes back to
  assign sift_ret = phase_r ? S_EXT_CHK : S_BUILD_NEXT;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_wr = 1'b1;
          if (in_last) begin
            state_nxt = S_BUILD_INIT;
          end
        end
      end
      S_BUILD_INIT: begin
        cmd.build_init = 1'b1;
        phase_nxt      = 1'b0;
        state_nxt      = S_BUILD_NEXT;
      end
      S_BUILD_NEXT: begin
        if (stat.i_zero) begin
          cmd.ext_init = 1'b1;
          phase_nxt    = 1'b1;
          state_nxt    = S_EXT_CHK;
        end else begin
          cmd.top_rd = 1'b1;
          cmd.i_dec  = 1'b1;
          state_nxt  = S_BUILD_LOAD;
        end
      end
      S_BUILD_LOAD: begin
        cmd.v_load = 1'b1;
        state_nxt  = S_SIFT_CHK;
      end
      S_SIFT_CHK: begin
        if (stat.c_ge_end) begin
          cmd.settle = 1'b1;
          state_nxt  = sift_ret;
        end else begin
          cmd.child_rd = 1'b1;
          state_nxt    = S_SIFT_CMP;
        end
      end
      S_SIFT_CMP: begin
        if (stat.v_lt_big) begin
          cmd.step_down = 1'b1;
          state_nxt     = S_SIFT_CHK;
        end else begin
          cmd.settle = 1'b1;
          state_nxt  = sift_ret;
        end
      end
      S_EXT_CHK: begin
        if (stat.i_le1) begin
          cmd.out_init = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          cmd.ext_rd = 1'b1;
          state_nxt  = S_EXT_SWAP;
        end
      end
      S_EXT_SWAP: begin
        cmd.ext_swap = 1'b1;
        cmd.i_dec    = 1'b1;
        state_nxt    = S_SIFT_CHK;
      end
      S_OUT: begin
        cmd.out_rd = 1'b1;
        if (stat.k_last) begin
          state_nxt = S_OUT_END;
        end
      end
      S_OUT_END: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  // state and registered busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

`default_nettype wire

// File: rtl/heap_sort_engine.sv
// heap_sort_engine: batch sorter using an in-place max-heap heapsort
// depends on hs_pkg, hs_ctrl, hs_datapath
//
// channel  ports                        handshake
// input    start, busy, in_word         word taken when start && !busy
// result   out_valid, out_word          one-cycle strobe, cannot be held off
//
// loading takes one word per cycle while busy is low.
// the word marked last raises busy; it stays high through the heap build (n/2
// sifts), the extraction (n-1 sifts) and the result run; each sift walks down
// the heap one level per step until the held value settles into its hole.
// results come one per cycle, n in a row; busy drops at the edge taking the last.
// the receiver cannot stall; reset clears count, overflow flag, result strobe and sequencer only.
`default_nettype none

module heap_sort_engine
  import hs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_word_t in_word,
  output logic          out_valid,
  output out_word_t     out_word
);

  hs_cmd_t  cmd;
  hs_stat_t stat;
  logic     accept;

  assign accept = start && !busy;

  // sequencer
  hs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept),
    .in_last (in_word.last_item),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  // store and sift datapath
  hs_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_word   (in_word),
    .stat      (stat),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // results only come while the block is busy
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  // a last word starts the sort
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_word.last_item) |=> busy)
    else $error("last word did not start the sort");

  // a run is contiguous until its final word
  a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.last_result) |=> out_valid)
    else $error("gap in result run");

  // the final result frees the block
  a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.last_result) |=> !busy)
    else $error("block still busy after final result");

endmodule

`default_nettype wire
